### sv/sight_cone_test_top_macros.svh
// Assertion macros for the sight cone test block.
// Used by sight_cone_test_top; expects clk and rst in the including scope.
`ifndef SIGHT_CONE_TEST_TOP_MACROS_SVH
`define SIGHT_CONE_TEST_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// implication checked every cycle out of reset
`define SCT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sight cone check failed");
// implication checked in the cycle after the antecedent
`define SCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sight cone check failed");
`else
`define SCT_ASSERT_IMP(label, ante, cons)
`define SCT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### sv/sct_pkg.sv
// Shared types and constants of the sight cone test block.
// No dependencies; imported by every module of the block.
package sct_pkg;

  // fixed field widths
  localparam int DIR_W  = 16;   // Q1.15 direction components
  localparam int COS_W  = 16;   // Q1.15 cosine
  localparam int OFF_W  = 20;   // apex back offset
  localparam int RAD_W  = 52;   // squared radii
  localparam int FRAC   = 15;   // Q.15 fraction bits
  localparam int HALF_LSB = 16384;  // one half in Q.15, for round half up
  localparam int CM2_W  = 31;   // width of cos squared magnitude
  localparam int IDX_W  = 2;    // register index width

  localparam logic [RAD_W-1:0] FAR_RESET = {RAD_W{1'b1}};

  // register indexes of the write port
  typedef enum logic [IDX_W-1:0] {
    REG_COS    = 2'd0,
    REG_OFFSET = 2'd1,
    REG_NEAR   = 2'd2,
    REG_FAR    = 2'd3
  } reg_idx_t;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic signed [COS_W-1:0] cos_half_angle;
    logic [OFF_W-1:0]        backward_offset;
    logic [RAD_W-1:0]        near_radius_sq;
    logic [RAD_W-1:0]        far_radius_sq;
  } cfg_t;

endpackage

### sv/sct_apex.sv
// Apex shift and apex-to-target vector, two pipeline stages.
// Depends on sct_pkg.
module sct_apex #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [COORD_WIDTH-1:0]    in_start [3],
  input  logic signed [sct_pkg::DIR_W-1:0] in_dir [3],
  input  logic signed [COORD_WIDTH-1:0]    in_target [3],
  input  logic [sct_pkg::OFF_W-1:0]        offset,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [((COORD_WIDTH + 1 > sct_pkg::OFF_W + 1) ?
                        COORD_WIDTH + 1 : sct_pkg::OFF_W + 1):0] out_v [3],
  output logic signed [sct_pkg::DIR_W-1:0] out_dir [3]
);
  import sct_pkg::*;

  localparam int SW = COORD_WIDTH + 1;                    // target - start
  localparam int VW = ((SW > OFF_W + 1) ? SW : OFF_W + 1) + 1;
  localparam int PW = DIR_W + OFF_W + 1;                  // dir * offset, Q.15

  logic                  a_vld, b_vld;
  logic                  en_a, en_b;
  logic signed [PW-1:0]  p [3];
  logic signed [SW-1:0]  diff [3];
  logic signed [PW-1:0]  a_p [3];
  logic signed [SW-1:0]  a_diff [3];
  logic signed [DIR_W-1:0] a_dir [3];
  logic signed [PW-1:0]  q [3];
  logic signed [PW-1:0]  r [3];
  logic signed [VW-1:0]  v [3];
  logic signed [VW-1:0]  b_v [3];
  logic signed [DIR_W-1:0] b_dir [3];

  // stage enables: a stage loads when empty or when the next one moves
  assign en_b     = !b_vld || out_ready;
  assign en_a     = !a_vld || en_b;
  assign in_ready = en_a;

  // stage A: offset product and position difference
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p[i]    = PW'(in_dir[i]) * PW'($signed({1'b0, offset}));
      diff[i] = SW'(in_target[i]) - SW'(in_start[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en_a) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_p    <= p;
      a_diff <= diff;
      a_dir  <= in_dir;
    end
  end

  // stage B: round the shift half up to integer units and add
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i] = a_p[i] + PW'(HALF_LSB);
      r[i] = q[i] >>> FRAC;
      v[i] = VW'(a_diff[i]) + VW'(r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en_b) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_v   <= v;
      b_dir <= a_dir;
    end
  end

  assign out_valid = b_vld;
  assign out_v     = b_v;
  assign out_dir   = b_dir;

endmodule

### sv/sct_dot.sv
// Squared length and dot product of the apex vector, two pipeline stages.
// Depends on sct_pkg.
module sct_dot #(
  parameter int VW = 26
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [VW-1:0]             in_v [3],
  input  logic signed [sct_pkg::DIR_W-1:0] in_dir [3],
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2*VW-1:0]                  out_dist,
  output logic signed [VW+sct_pkg::DIR_W:0] out_dot
);
  import sct_pkg::*;

  localparam int SQW  = 2 * VW;          // one square, also the sum of three
  localparam int DPW  = VW + DIR_W;      // one v * dir product
  localparam int DOTW = VW + DIR_W + 1;  // sum of three products

  logic                   c_vld, d_vld;
  logic                   en_c, en_d;
  logic signed [SQW-1:0]  sq [3];
  logic signed [DPW-1:0]  dp [3];
  logic [SQW-1:0]         c_sq [3];
  logic signed [DPW-1:0]  c_dp [3];
  logic [SQW-1:0]         d_dist;
  logic signed [DOTW-1:0] d_dot;

  assign en_d     = !d_vld || out_ready;
  assign en_c     = !c_vld || en_d;
  assign in_ready = en_c;

  // stage C: per-axis products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq[i] = SQW'(in_v[i]) * SQW'(in_v[i]);
      dp[i] = DPW'(in_v[i]) * DPW'(in_dir[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en_c) begin
      c_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      for (int i = 0; i < 3; i++) begin
        c_sq[i] <= sq[i];   // square is never negative
        c_dp[i] <= dp[i];
      end
    end
  end

  // stage D: sums over the three axes
  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en_d) begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d) begin
      d_dist <= c_sq[0] + c_sq[1] + c_sq[2];
      d_dot  <= DOTW'(c_dp[0]) + DOTW'(c_dp[1]) + DOTW'(c_dp[2]);
    end
  end

  assign out_valid = d_vld;
  assign out_dist  = d_dist;
  assign out_dot   = d_dot;

endmodule

### sv/sct_cmp.sv
// Range test and square-root-free cone test, four stages ending in the
// output register. Depends on sct_pkg.
module sct_cmp #(
  parameter int VW = 26
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sct_pkg::cfg_t                     cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2*VW-1:0]                   in_dist,
  input  logic signed [VW+sct_pkg::DIR_W:0] in_dot,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              in_cone,
  output logic                              in_range
);
  import sct_pkg::*;

  localparam int DW   = 2 * VW;                  // squared distance
  localparam int DOTW = VW + DIR_W + 1;
  localparam int DMW  = DOTW - 1;                // |dot|
  localparam int RW   = (DW > RAD_W) ? DW : RAD_W;
  localparam int LO   = DMW / 2;                 // |dot| split for squaring
  localparam int HI   = DMW - LO;
  localparam int PC   = (DW + 2) / 3;            // distance split into thirds
  localparam int PT   = DW - 2 * PC;
  localparam int DSQW = 2 * DMW;
  localparam int CSQW = DW + CM2_W;
  localparam int MW   = (DSQW > CSQW) ? DSQW : CSQW;
  localparam int CPW  = 2 * COS_W;

  logic en_e, en_f, en_g, en_h;
  logic e_vld, f_vld, g_vld, h_vld;

  // flags that ride along with the wide values
  logic e_rng, e_zero, e_dneg, e_cneg;
  logic f_rng, f_zero, f_dneg, f_cneg;
  logic g_rng, g_zero, g_dneg, g_cneg;

  logic signed [DOTW-1:0] dot_abs;
  logic signed [CPW-1:0]  cos_sq;
  logic [DW-1:0]          e_dist;
  logic [DMW-1:0]         e_dm;
  logic [CM2_W-1:0]       e_cm2;

  logic [2*LO-1:0]        f_pll;
  logic [LO+HI-1:0]       f_plh;
  logic [2*HI-1:0]        f_phh;
  logic [PC+CM2_W-1:0]    f_c0, f_c1;
  logic [PT+CM2_W-1:0]    f_c2;

  logic [MW-1:0]          g_dsq, g_csq;
  logic                   cone;
  logic                   h_cone, h_rng;

  assign en_h     = !h_vld || out_ready;
  assign en_g     = !g_vld || en_h;
  assign en_f     = !f_vld || en_g;
  assign en_e     = !e_vld || en_f;
  assign in_ready = en_e;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
      f_vld <= 1'b0;
      g_vld <= 1'b0;
      h_vld <= 1'b0;
    end else begin
      if (en_e) e_vld <= in_valid;
      if (en_f) f_vld <= e_vld;
      if (en_g) g_vld <= f_vld;
      if (en_h) h_vld <= g_vld;
    end
  end

  // stage E: range compares, signs, magnitudes
  assign dot_abs = in_dot[DOTW-1] ? -in_dot : in_dot;
  assign cos_sq  = CPW'(cfg.cos_half_angle) * CPW'(cfg.cos_half_angle);

  always_ff @(posedge clk) begin
    if (en_e) begin
      e_rng  <= (RW'(in_dist) <= RW'(cfg.far_radius_sq)) &&
                (RW'(in_dist) >= RW'(cfg.near_radius_sq));
      e_zero <= (in_dist == '0);
      e_dneg <= in_dot[DOTW-1];
      e_cneg <= cfg.cos_half_angle[COS_W-1];
      e_dist <= in_dist;
      e_dm   <= dot_abs[DMW-1:0];
      e_cm2  <= cos_sq[CM2_W-1:0];
    end
  end

  // stage F: partial products of dot^2 and cos^2 * dist
  always_ff @(posedge clk) begin
    if (en_f) begin
      f_pll  <= (2*LO)'(e_dm[LO-1:0]) * (2*LO)'(e_dm[LO-1:0]);
      f_plh  <= (LO+HI)'(e_dm[LO-1:0]) * (LO+HI)'(e_dm[DMW-1:LO]);
      f_phh  <= (2*HI)'(e_dm[DMW-1:LO]) * (2*HI)'(e_dm[DMW-1:LO]);
      f_c0   <= (PC+CM2_W)'(e_dist[PC-1:0]) * (PC+CM2_W)'(e_cm2);
      f_c1   <= (PC+CM2_W)'(e_dist[2*PC-1:PC]) * (PC+CM2_W)'(e_cm2);
      f_c2   <= (PT+CM2_W)'(e_dist[DW-1:2*PC]) * (PT+CM2_W)'(e_cm2);
      f_rng  <= e_rng;
      f_zero <= e_zero;
      f_dneg <= e_dneg;
      f_cneg <= e_cneg;
    end
  end

  // stage G: assemble the two wide products
  always_ff @(posedge clk) begin
    if (en_g) begin
      g_dsq  <= (MW'(f_phh) << (2 * LO)) + (MW'(f_plh) << (LO + 1)) + MW'(f_pll);
      g_csq  <= MW'(f_c0) + (MW'(f_c1) << PC) + (MW'(f_c2) << (2 * PC));
      g_rng  <= f_rng;
      g_zero <= f_zero;
      g_dneg <= f_dneg;
      g_cneg <= f_cneg;
    end
  end

  // stage H: range and zero cases, then sign cases, then the magnitude compare
  always_comb begin
    if (!g_rng) begin
      cone = 1'b0;
    end else if (g_zero) begin
      cone = 1'b1;
    end else if (!g_dneg && g_cneg) begin
      cone = 1'b1;
    end else if (g_dneg && !g_cneg) begin
      cone = 1'b0;
    end else if (!g_dneg) begin
      cone = g_dsq > g_csq;
    end else begin
      cone = g_dsq < g_csq;
    end
  end

  always_ff @(posedge clk) begin
    if (en_h) begin
      h_cone <= cone;
      h_rng  <= g_rng;
    end
  end

  assign out_valid = h_vld;
  assign in_cone   = h_cone;
  assign in_range  = h_rng;

endmodule

### sv/sight_cone_test_top.sv
// Sight cone test: top level with configuration registers and stream ports.
// Depends on sct_pkg, sct_apex, sct_dot, sct_cmp and the assertion macros.
//
// Takes one query beat per clock while the output side keeps up, and returns
// one result beat per query, in order. The eight stages are: apex offset
// product, rounded apex vector, per-axis squares and dot terms, axis sums,
// range compare with magnitudes, split partial products, wide product
// assembly, and the cone decision in the output register. Each stage has its
// own valid bit and loads whenever it is empty or the stage after it moves,
// so bubbles close up and queries keep entering while a result waits on
// m_tready, until the pipe is full. Configuration is written through
// wr_en / wr_index / wr_data and must only change while no query is in flight.
`include "sight_cone_test_top_macros.svh"

module sight_cone_test_top #(
  parameter int COORD_WIDTH = 24
) (
  input  logic clk,
  input  logic rst,
  // query stream
  input  logic s_tvalid,
  output logic s_tready,
  // s_tdata, low to high: start_x, start_y, start_z, dir_x, dir_y, dir_z,
  //   target_x, target_y, target_z, zero fill to whole bytes
  input  logic [((6 * COORD_WIDTH + 48 + 7) / 8) * 8 - 1:0] s_tdata,
  // result stream
  output logic m_tvalid,
  input  logic m_tready,
  // m_tdata, low to high: in_cone, in_range, zero fill
  output logic [7:0] m_tdata,
  // register write port
  input  logic wr_en,
  input  logic [sct_pkg::IDX_W-1:0] wr_index,
  input  logic [sct_pkg::RAD_W-1:0] wr_data
);
  import sct_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int VW = ((CW + 1 > OFF_W + 1) ? CW + 1 : OFF_W + 1) + 1;
  localparam int DIR_BASE = 3 * CW;
  localparam int TGT_BASE = 3 * CW + 3 * DIR_W;

  cfg_t cfg;

  logic signed [CW-1:0]    start [3];
  logic signed [DIR_W-1:0] dir [3];
  logic signed [CW-1:0]    target [3];

  logic                    ap_valid, ap_ready;
  logic signed [VW-1:0]    ap_v [3];
  logic signed [DIR_W-1:0] ap_dir [3];

  logic                    dt_valid, dt_ready;
  logic [2*VW-1:0]         dt_dist;
  logic signed [VW+DIR_W:0] dt_dot;

  logic                    cone, rng;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_half_angle  <= '0;
      cfg.backward_offset <= '0;
      cfg.near_radius_sq  <= '0;
      cfg.far_radius_sq   <= FAR_RESET;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_COS:    cfg.cos_half_angle  <= wr_data[COS_W-1:0];
        REG_OFFSET: cfg.backward_offset <= wr_data[OFF_W-1:0];
        REG_NEAR:   cfg.near_radius_sq  <= wr_data;
        REG_FAR:    cfg.far_radius_sq   <= wr_data;
        default: ;
      endcase
    end
  end

  // unpack the query beat
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      start[i]  = s_tdata[i*CW +: CW];
      dir[i]    = s_tdata[DIR_BASE + i*DIR_W +: DIR_W];
      target[i] = s_tdata[TGT_BASE + i*CW +: CW];
    end
  end

  sct_apex #(
    .COORD_WIDTH (CW)
  ) u_apex (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_start  (start),
    .in_dir    (dir),
    .in_target (target),
    .offset    (cfg.backward_offset),
    .out_valid (ap_valid),
    .out_ready (ap_ready),
    .out_v     (ap_v),
    .out_dir   (ap_dir)
  );

  sct_dot #(
    .VW (VW)
  ) u_dot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ap_valid),
    .in_ready  (ap_ready),
    .in_v      (ap_v),
    .in_dir    (ap_dir),
    .out_valid (dt_valid),
    .out_ready (dt_ready),
    .out_dist  (dt_dist),
    .out_dot   (dt_dot)
  );

  sct_cmp #(
    .VW (VW)
  ) u_cmp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (dt_valid),
    .in_ready  (dt_ready),
    .in_dist   (dt_dist),
    .in_dot    (dt_dot),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .in_cone   (cone),
    .in_range  (rng)
  );

  assign m_tdata = {6'b0, rng, cone};

  // a target in the cone is always in range
  `SCT_ASSERT_IMP(a_cone_needs_range, m_tvalid, (!m_tdata[0] || m_tdata[1]))
  // the input side only stalls when the whole pipe is backed up by the output
  `SCT_ASSERT_IMP(a_stall_from_output, !s_tready, (m_tvalid && !m_tready))
  // a full pipe that is released takes input again in the same cycle
  `SCT_ASSERT_IMP(a_release_opens_input, (m_tvalid && m_tready), s_tready)

endmodule

### verif/sight_cone_test_checker.sv
// Checker for the sight cone test block: watches the query, result and register ports.
// Predicts each verdict from its own copy of the registers; depends on sct_pkg.
`timescale 1ns / 100ps

module sight_cone_test_checker #(
  parameter int COORD_WIDTH = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  logic s_tready,
  // s_tdata, low to high: start_x/y/z, dir_x/y/z, target_x/y/z, zero fill
  input  logic [((6 * COORD_WIDTH + 48 + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic m_tvalid,
  input  logic m_tready,
  // m_tdata, low to high: in_cone, in_range, zero fill
  input  logic [7:0] m_tdata,
  input  logic wr_en,
  input  logic [sct_pkg::IDX_W-1:0] wr_index,
  input  logic [sct_pkg::RAD_W-1:0] wr_data,
  output int outstanding,
  output int errors
);
  import sct_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int BEAT_W = ((6 * CW + 48 + 7) / 8) * 8;

  typedef struct packed {
    logic in_range;
    logic in_cone;
  } verdict_t;

  // register mirror
  logic signed [COS_W-1:0] cfg_cos;
  logic [OFF_W-1:0]        cfg_offset;
  logic [RAD_W-1:0]        cfg_near;
  logic [RAD_W-1:0]        cfg_far;

  verdict_t pending_verdicts[$];
  int       fail_count = 0;

  assign errors = fail_count;

  // Exact visibility verdict for one query beat under the current registers.
  // Everything is carried at 128 bits signed, so no term can wrap.
  function automatic verdict_t predict_visibility(input logic [BEAT_W-1:0] beat);
    verdict_t              verdict;
    logic signed [CW-1:0]  from_c, to_c;
    logic signed [DIR_W-1:0] dir_c;
    logic signed [127:0]   dir_w, off_w, apex_r, vec_c, dist_sq, dot_sum;
    logic signed [127:0]   dot_sq, cos_w, bound, near_w, far_w;
    dist_sq = 0;
    dot_sum = 0;
    off_w   = cfg_offset;
    for (int i = 0; i < 3; i++) begin
      from_c = beat[i*CW +: CW];
      dir_c  = beat[3*CW + i*DIR_W +: DIR_W];
      to_c   = beat[3*CW + 3*DIR_W + i*CW +: CW];
      dir_w  = dir_c;
      // apex pulled back: Q.15 product rounded half up to whole units
      apex_r = (dir_w * off_w + HALF_LSB) >>> FRAC;
      vec_c  = to_c - from_c + apex_r;
      dist_sq = dist_sq + vec_c * vec_c;
      dot_sum = dot_sum + vec_c * dir_w;
    end
    near_w = cfg_near;
    far_w  = cfg_far;
    verdict.in_range = (dist_sq <= far_w) && (dist_sq >= near_w);
    verdict.in_cone  = 1'b0;
    cos_w = cfg_cos;
    if (verdict.in_range) begin
      if (dist_sq == 0) begin
        verdict.in_cone = 1'b1;
      end else begin
        // dot / |v| > cos, squared with the signs handled first
        dot_sq = dot_sum * dot_sum;
        bound  = cos_w * cos_w * dist_sq;
        if (dot_sum >= 0 && cos_w < 0) verdict.in_cone = 1'b1;
        else if (dot_sum < 0 && cos_w >= 0) verdict.in_cone = 1'b0;
        else if (dot_sum >= 0) verdict.in_cone = dot_sq > bound;
        else verdict.in_cone = dot_sq < bound;
      end
    end
    return verdict;
  endfunction

  // register writes, query predictions and result compares
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      cfg_cos    <= '0;
      cfg_offset <= '0;
      cfg_near   <= '0;
      cfg_far    <= FAR_RESET;
      pending_verdicts.delete();
    end else begin
      if (wr_en) begin
        case (reg_idx_t'(wr_index))
          REG_COS:    cfg_cos    <= wr_data[COS_W-1:0];
          REG_OFFSET: cfg_offset <= wr_data[OFF_W-1:0];
          REG_NEAR:   cfg_near   <= wr_data;
          REG_FAR:    cfg_far    <= wr_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) pending_verdicts.push_back(predict_visibility(s_tdata));
      if (m_tvalid && m_tready) begin
        if (pending_verdicts.size() == 0) begin
          $error("result beat with no query pending: m_tdata=%h", m_tdata);
          fail_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (m_tdata[0] !== want.in_cone) begin
            $error("in_cone: expected %0b, got %0b", want.in_cone, m_tdata[0]);
            fail_count++;
          end
          if (m_tdata[1] !== want.in_range) begin
            $error("in_range: expected %0b, got %0b", want.in_range, m_tdata[1]);
            fail_count++;
          end
        end
      end
    end
    outstanding <= pending_verdicts.size();
  end

endmodule

### verif/sight_cone_test_top_tb.sv
// Testbench top for sight_cone_test_top: clock, reset, query and register stimulus.
// Depends on sct_pkg, the block's RTL and sight_cone_test_checker.
`timescale 1ns / 100ps

module sight_cone_test_top_tb;
  import sct_pkg::*;

  localparam int COORD_W     = 24;
  localparam int BEAT_W      = ((6 * COORD_W + 48 + 7) / 8) * 8;
  localparam int MAXC        = (1 << (COORD_W - 1)) - 1;
  localparam int MINC        = -(1 << (COORD_W - 1));
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 16;
  localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};

  logic              clk;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [BEAT_W-1:0] s_tdata  = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;
  logic              wr_en    = 1'b0;
  logic [IDX_W-1:0]  wr_index = '0;
  logic [RAD_W-1:0]  wr_data  = '0;

  int               outstanding;
  int               errors;
  int               idle_pct   = 25;
  int               hold_left  = 0;
  int               cycle_count = 0;
  logic [OFF_W-1:0] cur_offset = '0;

  sight_cone_test_top #(.COORD_WIDTH(COORD_W)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  sight_cone_test_checker #(.COORD_WIDTH(COORD_W)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .outstanding(outstanding), .errors(errors)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      m_tready  <= 1'b0;
      hold_left <= $urandom_range(0, 16);
    end else begin
      m_tready  <= 1'b1;
      hold_left <= $urandom_range(0, 3);
    end
  end

  function automatic logic [BEAT_W-1:0] make_query(input int sx, sy, sz, dx, dy, dz,
                                                    input int tx, ty, tz);
    logic [BEAT_W-1:0] beat;
    beat = '0;
    beat[0*COORD_W +: COORD_W] = sx[COORD_W-1:0];
    beat[1*COORD_W +: COORD_W] = sy[COORD_W-1:0];
    beat[2*COORD_W +: COORD_W] = sz[COORD_W-1:0];
    beat[3*COORD_W + 0*DIR_W +: DIR_W] = dx[DIR_W-1:0];
    beat[3*COORD_W + 1*DIR_W +: DIR_W] = dy[DIR_W-1:0];
    beat[3*COORD_W + 2*DIR_W +: DIR_W] = dz[DIR_W-1:0];
    beat[3*COORD_W + 3*DIR_W + 0*COORD_W +: COORD_W] = tx[COORD_W-1:0];
    beat[3*COORD_W + 3*DIR_W + 1*COORD_W +: COORD_W] = ty[COORD_W-1:0];
    beat[3*COORD_W + 3*DIR_W + 2*COORD_W +: COORD_W] = tz[COORD_W-1:0];
    return beat;
  endfunction

  // Mostly targets placed along the view direction with jitter; the rest raw
  // random bits or targets sitting exactly on the shifted apex.
  function automatic logic [BEAT_W-1:0] random_query();
    logic [BEAT_W-1:0] beat;
    int  sel, reach, amp, jitter;
    int  base[3], dv[3], tv[3];
    real ax, ay, az, norm;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      beat = '0;
      for (int k = 0; k < BEAT_W; k += 32) beat = {beat[BEAT_W-33:0], 32'($urandom)};
      return beat;
    end
    for (int i = 0; i < 3; i++) begin
      base[i] = $urandom_range(0, 1 << (COORD_W - 1));
      base[i] = base[i] - (1 << (COORD_W - 2));
    end
    if (sel < 40) begin
      for (int i = 0; i < 3; i++) dv[i] = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      ax = $urandom_range(0, 2000) / 1000.0 - 1.0;
      ay = $urandom_range(0, 2000) / 1000.0 - 1.0;
      az = $urandom_range(0, 2000) / 1000.0 - 1.0;
      norm = $sqrt(ax * ax + ay * ay + az * az);
      if (norm < 0.05) begin
        ax = 1.0; ay = 0.0; az = 0.0; norm = 1.0;
      end
      dv[0] = $rtoi(ax / norm * 32767.0);
      dv[1] = $rtoi(ay / norm * 32767.0);
      dv[2] = $rtoi(az / norm * 32767.0);
    end
    if (sel < 25) begin
      // target on the apex: zero vector
      for (int i = 0; i < 3; i++)
        tv[i] = base[i] - int'((longint'(dv[i]) * longint'(cur_offset) + 16384) >>> 15);
    end else begin
      reach = $urandom_range(0, 1 << $urandom_range(0, COORD_W - 3));
      amp   = (reach >> $urandom_range(0, 8)) + $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
        jitter = $urandom_range(0, 2 * amp);
        tv[i]  = base[i] + int'((longint'(dv[i]) * reach) >>> 15) + jitter - amp;
      end
    end
    return make_query(base[0], base[1], base[2], dv[0], dv[1], dv[2], tv[0], tv[1], tv[2]);
  endfunction

  function automatic logic [RAD_W-1:0] random_radius(input int min_shift);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[RAD_W-1:0] >> $urandom_range(min_shift, RAD_W - 1);
  endfunction

  // one query beat, with an optional idle burst ahead of it
  task automatic send_query(input logic [BEAT_W-1:0] beat);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending and wait until every verdict has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [RAD_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [COS_W-1:0] cos_v, input logic [OFF_W-1:0] off_v,
                             input logic [RAD_W-1:0] near_v, input logic [RAD_W-1:0] far_v);
    write_reg(REG_COS, {{(RAD_W - COS_W){1'b0}}, cos_v});
    write_reg(REG_OFFSET, {{(RAD_W - OFF_W){1'b0}}, off_v});
    write_reg(REG_NEAR, near_v);
    write_reg(REG_FAR, far_v);
    wr_en      <= 1'b0;
    cur_offset = off_v;
  endtask

  task automatic random_config();
    logic [COS_W-1:0] cos_v;
    logic [OFF_W-1:0] off_v;
    logic [RAD_W-1:0] near_v, far_v;
    case ($urandom_range(0, 5))
      0:       cos_v = 16'h8000;
      1:       cos_v = 16'h7fff;
      2:       cos_v = '0;
      3:       cos_v = COS_W'($urandom_range(0, 65535));
      default: cos_v = COS_W'($urandom_range(16000, 32767));
    endcase
    case ($urandom_range(0, 3))
      0:       off_v = '0;
      1:       off_v = {OFF_W{1'b1}};
      2:       off_v = OFF_W'($urandom_range(0, 255));
      default: off_v = OFF_W'($urandom_range(0, (1 << OFF_W) - 1));
    endcase
    if ($urandom_range(0, 2) == 0) begin
      near_v = '0;
      far_v  = RAD_MAX;
    end else begin
      near_v = random_radius(10);
      far_v  = near_v + random_radius(6);
    end
    load_config(cos_v, off_v, near_v, far_v);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: cos 0, no offset, full range
    send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(make_query(MAXC, MAXC, MAXC, 32767, 32767, 32767, MINC, MINC, MINC));
    send_query(make_query(MINC, MINC, MINC, 32767, 32767, 32767, MAXC, MAXC, MAXC));
    send_query(make_query(0, 0, 0, -32768, -32768, -32768, -100, -100, -100));
    send_query(make_query(1234, -5678, 42, 32767, 0, 0, 1234, -5678, 42));
    send_query(make_query(0, 0, 0, 0, 32767, 0, 100, 0, 0));
    send_query(make_query(10, 20, 30, 0, 0, 0, 11, 20, 30));
    send_query(make_query(MINC, MAXC, MINC, -32768, 32767, -1, MAXC, MINC, MAXC));
    drain_results();

    // widest cone, apex rounding at the half point, target dead behind
    load_config(16'h8000, 20'd16384, '0, RAD_MAX);
    send_query(make_query(0, 0, 0, 1, -1, 3, 0, 0, 0));
    send_query(make_query(0, 0, 0, -32768, 0, 0, 16389, 0, 0));
    send_query(make_query(0, 0, 0, 32767, 0, 0, 0, 5, 0));
    drain_results();

    // narrowest cone, largest offset, range pinned to exactly 100
    load_config(16'h7fff, {OFF_W{1'b1}}, 52'd100, 52'd100);
    send_query(make_query(0, 0, 0, 0, 0, 0, 6, 8, 0));
    send_query(make_query(0, 0, 0, 32767, 0, 0, -1048533, 0, 0));
    send_query(make_query(0, 0, 0, 0, 0, 0, 1, 7, 7));
    send_query(make_query(0, 0, 0, 0, 0, 0, 6, 8, 1));
    send_query(make_query(5, 5, 5, 0, 0, 0, 5, 5, 5));
    drain_results();

    // near above far: nothing can be in range
    load_config('0, '0, RAD_MAX, '0);
    send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(make_query(MAXC, MAXC, MAXC, 32767, 32767, 32767, MINC, MINC, MINC));
    drain_results();

    // random phases; one quiet stretch midway and a quiet tail
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2 || phase == 5) idle_pct = 0;
      else idle_pct = $urandom_range(15, 50);
      random_config();
      repeat (66) send_query(random_query());
      drain_results();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/sct_pkg.sv
sv/sct_apex.sv
sv/sct_dot.sv
sv/sct_cmp.sv
sv/sight_cone_test_top.sv
verif/sight_cone_test_checker.sv
verif/sight_cone_test_top_tb.sv
